// ----- design/fem_pkg.sv -----
// Shared types and constants for the forecast error metrics block.
`default_nettype none

package fem_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int SUM_W          = 48;
    localparam int MAPE_W         = 32;
    localparam int SMAPE_W        = 24;
    localparam int DA_W           = 23;
    localparam int ME_W           = 32;
    localparam int DSR_W          = SAMPLE_W + 1;
    localparam int DIV_CNT_W      = 6;
    localparam int PCT_SCALE      = 100;
    localparam int PCT_W          = 7;
    localparam int SAPE_ZERO_TERM = 2;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_req;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_PREP    = 12'b0000_0000_0010,
        ST_ABS     = 12'b0000_0000_0100,
        ST_APE_GO  = 12'b0000_0000_1000,
        ST_APE_W   = 12'b0000_0001_0000,
        ST_SAPE_GO = 12'b0000_0010_0000,
        ST_SAPE_W  = 12'b0000_0100_0000,
        ST_UPD     = 12'b0000_1000_0000,
        ST_FLOAD   = 12'b0001_0000_0000,
        ST_FGO     = 12'b0010_0000_0000,
        ST_FWAIT   = 12'b0100_0000_0000,
        ST_EMIT    = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        F_MAPE  = 2'd0,
        F_SMAPE = 2'd1,
        F_DA    = 2'd2,
        F_ME    = 2'd3
    } t_fsel;

endpackage

`default_nettype wire

// ----- design/fem_div.sv -----
// Shared radix-2 restoring unsigned divider, one quotient bit per cycle.
`default_nettype none

module fem_div #(
    parameter int DIVW = 55,
    parameter int DSW  = 33
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire fem_pkg::t_div_req   i_req,
    input  wire logic [DIVW-1:0]     i_dividend,
    input  wire logic [DSW-1:0]      i_divisor,
    output logic                     o_done,
    output logic [DIVW-1:0]          o_quotient
);
    import fem_pkg::*;

    localparam logic [DIV_CNT_W-1:0] DIVW_C = DIV_CNT_W'(DIVW);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DSW-1:0]       r_rem;
    logic [DSW-1:0]       r_dsr;
    logic [DIVW-1:0]      r_quo;

    logic [DSW:0]         w_trial;
    logic [DSW+1:0]       w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[DIVW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_dsr};
    assign w_ge    = ~w_diff[DSW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.nbits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend is left-aligned so that only its significant bits are walked.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_dividend << (DIVW_C - i_req.nbits);
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DSW-1:0] : w_trial[DSW-1:0];
            r_quo <= {r_quo[DIVW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

// ----- design/forecast_error_metrics.sv -----
// Top level: MAPE, SMAPE, directional accuracy and mean error over a window of pairs.
// Each pair runs up to two percentage divisions, one after the other, through the shared
// radix-2 divider; the closing pair of a window adds four more divisions.
// A result waiting in the output register does not hold off the next input transaction.
// Synchronous active-low reset clears the accumulators, the sequencer and the output valid.
`default_nettype none

module forecast_error_metrics #(
    parameter int MAX_WINDOW = 1024,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [31:0] actual_value, [63:32] forecast_value
    input  wire logic [63:0]  i_s_axis_tdata,
    // window_last
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [31:0] mape_percent, [55:32] smape_percent, [78:56] direction_percent,
    // [110:79] mean_error, [111] zero_divisor_seen
    output logic [111:0]      o_m_axis_tdata
);
    import fem_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int MUL_W = SUM_W + PCT_W;
    localparam int DIVW  = (SAMPLE_W + 1 + FRAC_BITS > MUL_W) ?
                           SAMPLE_W + 1 + FRAC_BITS : MUL_W;

    localparam logic [DIV_CNT_W-1:0] NB_APE  = DIV_CNT_W'(SAMPLE_W + FRAC_BITS);
    localparam logic [DIV_CNT_W-1:0] NB_SAPE = DIV_CNT_W'(SAMPLE_W + 1 + FRAC_BITS);
    localparam logic [DIV_CNT_W-1:0] NB_FIN  = DIV_CNT_W'(DIVW);
    localparam logic [CNT_W-1:0]     MAXW_C  = CNT_W'(MAX_WINDOW);

    localparam logic [SUM_W-1:0] APE_SAT   = {{(SUM_W-MAPE_W){1'b0}}, {MAPE_W{1'b1}}};
    localparam logic [SUM_W-1:0] SAPE_ZERO = SUM_W'(SAPE_ZERO_TERM) << FRAC_BITS;
    localparam logic [SUM_W-1:0] SE_MAX    = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SE_MIN    = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [ME_W-1:0]  ME_MAX    = {1'b0, {(ME_W-1){1'b1}}};
    localparam logic [ME_W-1:0]  ME_MIN    = {1'b1, {(ME_W-1){1'b0}}};

    function automatic logic [SUM_W-1:0] f_sat_add(input logic [SUM_W-1:0] s,
                                                   input logic [SUM_W-1:0] t);
        logic [SUM_W:0] r;
        r = {1'b0, s} + {1'b0, t};
        return r[SUM_W] ? {SUM_W{1'b1}} : r[SUM_W-1:0];
    endfunction

    function automatic logic [MUL_W-1:0] f_mul100(input logic [SUM_W-1:0] x);
        return MUL_W'(x) * MUL_W'(PCT_SCALE);
    endfunction

    // Sequencer and window state.
    t_state                    r_state;
    t_fsel                     r_fsel;
    logic                      r_ovalid;
    logic [SUM_W-1:0]          r_ape_sum;
    logic [SUM_W-1:0]          r_sape_sum;
    logic signed [SUM_W-1:0]   r_se_sum;
    logic [CNT_W-1:0]          r_hits;
    logic [CNT_W-1:0]          r_pairs;
    logic                      r_first;
    logic signed [SAMPLE_W-1:0] r_prev_a;
    logic signed [SAMPLE_W-1:0] r_prev_f;
    logic                      r_zflag;

    // Working registers of the current pair and of the closing divisions.
    logic signed [SAMPLE_W-1:0] r_a;
    logic signed [SAMPLE_W-1:0] r_f;
    logic                      r_last;
    logic signed [SAMPLE_W:0]  r_d;
    logic [SAMPLE_W-1:0]       r_aa;
    logic [SAMPLE_W-1:0]       r_af;
    logic [SAMPLE_W-1:0]       r_ad;
    logic [DSR_W-1:0]          r_den;
    logic                      r_hit;
    logic [DIVW-1:0]           r_num;
    logic                      r_me_neg;
    logic [MAPE_W-1:0]         r_res_mape;
    logic [SMAPE_W-1:0]        r_res_smape;
    logic [DA_W-1:0]           r_res_da;
    logic [ME_W-1:0]           r_res_me;
    logic [111:0]              r_odata;

    logic                      w_accept;
    logic                      w_emit;
    logic                      w_close;
    logic [CNT_W-1:0]          w_pairs_inc;
    t_div_req                  w_req;
    logic [DIVW-1:0]           w_dividend;
    logic [DSR_W-1:0]          w_divisor;
    logic                      w_div_done;
    logic [DIVW-1:0]           w_quo;
    logic [SUM_W-1:0]          w_ape_term;
    logic signed [SUM_W:0]     w_se_wide;
    logic [SUM_W-1:0]          w_se_next;
    logic [SUM_W-1:0]          w_se_mag;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit          = (r_state == ST_EMIT) && (!r_ovalid || i_m_axis_tready);
    assign w_pairs_inc     = r_pairs + 1'b1;
    assign w_close         = r_last || (w_pairs_inc == MAXW_C);

    assign w_ape_term = (|w_quo[DIVW-1:MAPE_W]) ? APE_SAT : SUM_W'(w_quo[MAPE_W-1:0]);

    assign w_se_wide = (SUM_W+1)'(r_se_sum) + (SUM_W+1)'(r_d);
    assign w_se_next = (w_se_wide[SUM_W] != w_se_wide[SUM_W-1]) ?
                       (w_se_wide[SUM_W] ? SE_MIN : SE_MAX) : w_se_wide[SUM_W-1:0];
    assign w_se_mag  = r_se_sum[SUM_W-1] ? SUM_W'(-r_se_sum) : SUM_W'(r_se_sum);

    always_comb begin
        w_req.start = 1'b0;
        w_req.nbits = NB_FIN;
        w_dividend  = r_num;
        w_divisor   = DSR_W'(r_pairs);
        unique case (r_state)
            ST_APE_GO: begin
                w_req.start = (r_aa != '0);
                w_req.nbits = NB_APE;
                w_dividend  = DIVW'(r_ad) << FRAC_BITS;
                w_divisor   = DSR_W'(r_aa);
            end
            ST_SAPE_GO: begin
                w_req.start = (r_den != '0);
                w_req.nbits = NB_SAPE;
                w_dividend  = DIVW'({r_ad, 1'b0}) << FRAC_BITS;
                w_divisor   = r_den;
            end
            ST_FGO: begin
                w_req.start = 1'b1;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    fem_div #(
        .DIVW (DIVW),
        .DSW  (DSR_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_fsel     <= F_MAPE;
            r_ovalid   <= 1'b0;
            r_ape_sum  <= '0;
            r_sape_sum <= '0;
            r_se_sum   <= '0;
            r_hits     <= '0;
            r_pairs    <= '0;
            r_first    <= 1'b1;
            r_prev_a   <= '0;
            r_prev_f   <= '0;
            r_zflag    <= 1'b0;
        end else begin
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    r_state <= ST_ABS;
                end
                ST_ABS: begin
                    r_state <= ST_APE_GO;
                end
                ST_APE_GO: begin
                    if (r_aa == '0) begin
                        r_ape_sum <= f_sat_add(r_ape_sum, APE_SAT);
                        r_zflag   <= 1'b1;
                        r_state   <= ST_SAPE_GO;
                    end else begin
                        r_state <= ST_APE_W;
                    end
                end
                ST_APE_W: begin
                    if (w_div_done) begin
                        r_ape_sum <= f_sat_add(r_ape_sum, w_ape_term);
                        r_state   <= ST_SAPE_GO;
                    end
                end
                ST_SAPE_GO: begin
                    if (r_den == '0) begin
                        r_sape_sum <= f_sat_add(r_sape_sum, SAPE_ZERO);
                        r_zflag    <= 1'b1;
                        r_state    <= ST_UPD;
                    end else begin
                        r_state <= ST_SAPE_W;
                    end
                end
                ST_SAPE_W: begin
                    // The symmetric term never exceeds two, so no clamp is needed here.
                    if (w_div_done) begin
                        r_sape_sum <= f_sat_add(r_sape_sum, w_quo[SUM_W-1:0]);
                        r_state    <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    r_se_sum <= w_se_next;
                    r_hits   <= r_hits + CNT_W'(r_hit);
                    r_prev_a <= r_a;
                    r_prev_f <= r_f;
                    r_first  <= 1'b0;
                    r_pairs  <= w_pairs_inc;
                    if (w_close) begin
                        r_fsel  <= F_MAPE;
                        r_state <= ST_FLOAD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_FLOAD: begin
                    r_state <= ST_FGO;
                end
                ST_FGO: begin
                    r_state <= ST_FWAIT;
                end
                ST_FWAIT: begin
                    if (w_div_done) begin
                        unique case (r_fsel)
                            F_MAPE: begin
                                r_fsel  <= F_SMAPE;
                                r_state <= ST_FLOAD;
                            end
                            F_SMAPE: begin
                                r_fsel  <= F_DA;
                                r_state <= ST_FLOAD;
                            end
                            F_DA: begin
                                r_fsel  <= F_ME;
                                r_state <= ST_FLOAD;
                            end
                            F_ME: begin
                                r_state <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (w_emit) begin
                        r_ape_sum  <= '0;
                        r_sape_sum <= '0;
                        r_se_sum   <= '0;
                        r_hits     <= '0;
                        r_pairs    <= '0;
                        r_first    <= 1'b1;
                        r_prev_a   <= '0;
                        r_prev_f   <= '0;
                        r_zflag    <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_a    <= i_s_axis_tdata[31:0];
                    r_f    <= i_s_axis_tdata[63:32];
                    r_last <= i_s_axis_tlast;
                end
            end
            ST_PREP: begin
                r_d   <= (SAMPLE_W+1)'(r_a) - (SAMPLE_W+1)'(r_f);
                r_aa  <= r_a[SAMPLE_W-1] ? SAMPLE_W'(-r_a) : SAMPLE_W'(r_a);
                r_af  <= r_f[SAMPLE_W-1] ? SAMPLE_W'(-r_f) : SAMPLE_W'(r_f);
                r_hit <= !r_first && (((r_a > r_prev_a) && (r_f > r_prev_f)) ||
                                      ((r_a < r_prev_a) && (r_f < r_prev_f)));
            end
            ST_ABS: begin
                r_ad  <= r_d[SAMPLE_W] ? SAMPLE_W'(-r_d) : r_d[SAMPLE_W-1:0];
                r_den <= {1'b0, r_aa} + {1'b0, r_af};
            end
            ST_FLOAD: begin
                r_me_neg <= r_se_sum[SUM_W-1];
                unique case (r_fsel)
                    F_MAPE:  r_num <= DIVW'(f_mul100(r_ape_sum));
                    F_SMAPE: r_num <= DIVW'(f_mul100(r_sape_sum));
                    F_DA:    r_num <= DIVW'(f_mul100(SUM_W'(r_hits))) << FRAC_BITS;
                    F_ME:    r_num <= DIVW'(w_se_mag);
                endcase
            end
            ST_FWAIT: begin
                if (w_div_done) begin
                    unique case (r_fsel)
                        F_MAPE: begin
                            r_res_mape <= (|w_quo[DIVW-1:MAPE_W]) ? {MAPE_W{1'b1}} :
                                          w_quo[MAPE_W-1:0];
                        end
                        F_SMAPE: begin
                            r_res_smape <= (|w_quo[DIVW-1:SMAPE_W]) ? {SMAPE_W{1'b1}} :
                                           w_quo[SMAPE_W-1:0];
                        end
                        F_DA: begin
                            r_res_da <= (|w_quo[DIVW-1:DA_W]) ? {DA_W{1'b1}} :
                                        w_quo[DA_W-1:0];
                        end
                        F_ME: begin
                            // Magnitude division truncates toward zero; the sign goes back after.
                            if (r_me_neg) begin
                                r_res_me <= (|w_quo[DIVW-1:ME_W-1]) ? ME_MIN :
                                            -w_quo[ME_W-1:0];
                            end else begin
                                r_res_me <= (|w_quo[DIVW-1:ME_W-1]) ? ME_MAX :
                                            w_quo[ME_W-1:0];
                            end
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (w_emit) begin
                    r_odata <= {r_zflag, r_res_me, r_res_da, r_res_smape, r_res_mape};
                end
            end
            default: begin
                r_hit <= r_hit;
            end
        endcase
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

`default_nettype wire

// ----- bench/tb_forecast_error_metrics.sv -----
// Testbench for the forecast error metrics block: directed, overlong and random windows.
`timescale 1ns / 1ps

module tb_forecast_error_metrics;

    import fem_pkg::*;

    localparam int WINDOW_MAX   = 1024;
    localparam int FRAC         = 16;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 600;

    localparam longint unsigned SUM_CEIL  = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint          ERR_CEIL  = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          ERR_FLOOR = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic [MAPE_W-1:0]  mape;
        logic [SMAPE_W-1:0] smape;
        logic [DA_W-1:0]    da;
        logic [ME_W-1:0]    me;
        logic               zflag;
    } t_metrics;

    logic         i_clk    = 1'b0;
    logic         i_rst_n  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [63:0]  s_tdata  = '0;
    logic         s_tlast  = 1'b0;
    logic         m_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [111:0] o_m_axis_tdata;

    bit       idle_off = 1'b0;
    int       errors = 0;
    int       stall_cycles = 0;
    t_metrics pending_metrics[$];

    // Running window state of the predictor.
    longint          last_actual = 0;
    longint          last_forecast = 0;
    bit              window_fresh = 1'b1;
    longint unsigned ape_acc = 0;
    longint unsigned sape_acc = 0;
    longint          err_acc = 0;
    longint unsigned hits = 0;
    longint unsigned pairs = 0;
    bit              zero_seen = 1'b0;

    forecast_error_metrics #(
        .MAX_WINDOW (WINDOW_MAX),
        .FRAC_BITS  (FRAC)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        // [31:0] actual_value, [63:32] forecast_value
        .i_s_axis_tdata  (s_tdata),
        // window_last
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        // [31:0] mape_percent, [55:32] smape_percent, [78:56] direction_percent,
        // [110:79] mean_error, [111] zero_divisor_seen
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit take_break();
        return !idle_off && ($urandom_range(99) < 30);
    endfunction

    function automatic void clear_window();
        last_actual   = 0;
        last_forecast = 0;
        window_fresh  = 1'b1;
        ape_acc       = 0;
        sape_acc      = 0;
        err_acc       = 0;
        hits          = 0;
        pairs         = 0;
        zero_seen     = 1'b0;
    endfunction

    // Folds one accepted pair into the window and queues the metrics when it closes.
    function automatic void fold_pair(input logic [31:0] a_bits, input logic [31:0] f_bits,
                                      input logic last);
        longint          a;
        longint          f;
        longint          d;
        longint          se;
        longint          me;
        longint unsigned ad;
        longint unsigned aa;
        longint unsigned af;
        longint unsigned term;
        longint unsigned den;
        longint unsigned v;
        t_metrics        m;
        a  = longint'($signed(a_bits));
        f  = longint'($signed(f_bits));
        d  = a - f;
        ad = (d < 0) ? longint'(-d) : d;
        aa = (a < 0) ? longint'(-a) : a;
        af = (f < 0) ? longint'(-f) : f;

        if (aa == 0) begin
            term = 64'hFFFF_FFFF;
            zero_seen = 1'b1;
        end else begin
            term = (ad << FRAC) / aa;
            if (term > 64'hFFFF_FFFF) term = 64'hFFFF_FFFF;
        end
        ape_acc = ape_acc + term;
        if (ape_acc > SUM_CEIL) ape_acc = SUM_CEIL;

        den = aa + af;
        if (den == 0) begin
            term = 64'd2 << FRAC;
            zero_seen = 1'b1;
        end else begin
            term = ((64'd2 * ad) << FRAC) / den;
        end
        sape_acc = sape_acc + term;
        if (sape_acc > SUM_CEIL) sape_acc = SUM_CEIL;

        se = err_acc + d;
        if (se > ERR_CEIL) se = ERR_CEIL;
        if (se < ERR_FLOOR) se = ERR_FLOOR;
        err_acc = se;

        if (!window_fresh) begin
            if ((a > last_actual && f > last_forecast) || (a < last_actual && f < last_forecast))
                hits++;
        end
        window_fresh  = 1'b0;
        last_actual   = a;
        last_forecast = f;
        pairs++;

        // A window that reaches the maximum length closes on its own.
        if (!last && pairs < WINDOW_MAX) return;

        me = err_acc / longint'(pairs);
        if (me > 64'sh7FFF_FFFF) me = 64'sh7FFF_FFFF;
        if (me < -64'sh8000_0000) me = -64'sh8000_0000;
        m.me = me[ME_W-1:0];
        v = (ape_acc * 64'd100) / pairs;
        m.mape = (v > 64'hFFFF_FFFF) ? '1 : v[MAPE_W-1:0];
        v = (sape_acc * 64'd100) / pairs;
        m.smape = (v > 64'hFF_FFFF) ? '1 : v[SMAPE_W-1:0];
        v = ((hits * 64'd100) << FRAC) / pairs;
        m.da = (v > 64'h7F_FFFF) ? '1 : v[DA_W-1:0];
        m.zflag = zero_seen;
        pending_metrics.push_back(m);
        clear_window();
    endfunction

    // Offers one pair and returns at the edge where it was accepted, with tvalid still high.
    task automatic send_pair(input logic [31:0] a, input logic [31:0] f, input logic last);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {f, a};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        fold_pair(a, f, last);
    endtask

    task automatic test_single_pair_windows();
        send_pair(32'h0000_0000, 32'h0000_0000, 1'b1);  // both zero
        send_pair(32'h0000_0000, 32'h0005_0000, 1'b1);  // zero actual only
        send_pair(32'h0000_0001, 32'h7FFF_FFFF, 1'b1);  // percentage term clamps
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);  // mean error clamps high
        send_pair(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);  // mean error clamps low
        send_pair(32'h8000_0000, 32'h8000_0000, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'h0001_0000, 1'b1);
    endtask

    task automatic test_direction_hits();
        send_pair(32'd100, 32'd200, 1'b0);
        send_pair(32'd150, 32'd250, 1'b0);  // both rise
        send_pair(32'd120, 32'd220, 1'b0);  // both fall
        send_pair(32'd130, 32'd210, 1'b0);  // opposite directions
        send_pair(32'd130, 32'd230, 1'b0);  // actual flat
        send_pair(32'd90,  32'd230, 1'b0);  // forecast flat
        send_pair(32'd80,  32'd100, 1'b1);  // both fall
    endtask

    task automatic test_truncation();
        // Negative error sums divide toward zero.
        send_pair(32'd0, 32'd1, 1'b0);
        send_pair(32'd0, 32'd2, 1'b1);
        send_pair(32'd7, 32'd3, 1'b0);
        send_pair(32'd5, 32'd9, 1'b0);
        send_pair(32'hFFFF_FFF0, 32'd0, 1'b1);
    endtask

    task automatic test_overlong_window();
        logic [31:0] a;
        logic [31:0] f;
        int          step;
        a = 32'h0010_0000;
        f = 32'h000F_0000;
        for (int k = 0; k < WINDOW_MAX; k++) begin
            step = int'($urandom_range(4000)) - 2000;
            a = a + step;
            f = f + step + int'($urandom_range(200)) - 100;
            send_pair(a, f, 1'b0);
        end
        // The next pairs must start a fresh window.
        send_pair(32'h0002_0000, 32'h0001_0000, 1'b0);
        send_pair(32'h0003_0000, 32'h0002_0000, 1'b1);
    endtask

    task automatic test_random_windows(input int count);
        int          sent;
        int          len;
        int          mode;
        int          step;
        logic [31:0] a;
        logic [31:0] f;
        sent = 0;
        idle_off = 1'b1;
        while (sent < count) begin
            if (sent >= count / 3) idle_off = 1'b0;
            len  = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 1);
            mode = $urandom_range(9);
            a = $urandom_range(32'h00FF_FFFF);
            f = a + $urandom_range(32'h0003_FFFF) - 32'h0002_0000;
            for (int k = 0; k < len; k++) begin
                case (mode)
                    0, 1, 2: begin
                        step = int'($urandom_range(2000)) - 1000;
                        a = a + step;
                        f = f + step + int'($urandom_range(100)) - 50;
                    end
                    3: begin
                        a = a + int'($urandom_range(2000)) - 1000;
                        f = f + int'($urandom_range(2000)) - 1000;
                    end
                    4, 5: begin
                        a = $urandom;
                        f = $urandom;
                    end
                    6: begin
                        a = ($urandom_range(2) == 0) ? 32'd0 : $urandom;
                        f = $urandom;
                    end
                    7: begin
                        a = ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(255);
                        f = ($urandom_range(2) == 0) ? 32'd0 : $urandom_range(255);
                    end
                    8: begin
                        case ($urandom_range(4))
                            0: a = 32'h7FFF_FFFF;
                            1: a = 32'h8000_0000;
                            2: a = 32'hFFFF_FFFF;
                            3: a = 32'd1;
                            default: a = $urandom;
                        endcase
                        f = ($urandom_range(1) == 0) ? ~a : $urandom;
                    end
                    default: begin
                        a = $urandom;
                        f = a;
                    end
                endcase
                send_pair(a, f, k == len - 1);
                sent++;
            end
        end
        idle_off = 1'b0;
    endtask

    always @(posedge i_clk) begin
        m_tready <= !take_break();
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_metrics want;
        if (i_rst_n && o_m_axis_tvalid && m_tready) begin
            if (pending_metrics.size() == 0) begin
                $display("%0t: unexpected result transaction, expected none, actual %h",
                         $time, o_m_axis_tdata);
                errors++;
            end else begin
                want = pending_metrics.pop_front();
                compare_field("mape_percent", want.mape, o_m_axis_tdata[31:0]);
                compare_field("smape_percent", want.smape, o_m_axis_tdata[55:32]);
                compare_field("direction_percent", want.da, o_m_axis_tdata[78:56]);
                compare_field("mean_error", want.me, o_m_axis_tdata[110:79]);
                compare_field("zero_divisor_seen", want.zflag, o_m_axis_tdata[111]);
            end
        end
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_single_pair_windows();
        test_direction_hits();
        test_truncation();
        test_overlong_window();
        test_random_windows(450);
        s_tvalid <= 1'b0;
        while (pending_metrics.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
